@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared widths, status codes and controller/datapath signal groups for the
// stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // field widths
  localparam int PRIO_W  = 8;
  localparam int TAG_W   = 16;
  localparam int ENTRY_W = PRIO_W + TAG_W;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 5;

  // request kinds
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // response status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // which response the datapath builds
  typedef enum logic [1:0] {
    RES_ENQ_OK,
    RES_FULL,
    RES_EMPTY,
    RES_DEQ_OK
  } res_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load_req;   // capture request fields
    logic     start_enq;  // begin insertion walk at the tail
    logic     rd_prev;    // read the entry in front of the write slot
    logic     shift;      // move the read entry back by one slot
    logic     place;      // write the new entry into the write slot
    logic     rd_head;    // read the head entry
    logic     pop;        // remove the head entry
    logic     res_load;   // load the response register
    res_sel_t res_sel;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic deq_req;      // captured request is a dequeue
    logic full;
    logic empty;
    logic walk_done;    // write slot reached the head
    logic goes_behind;  // read entry has equal or higher priority
    logic out_busy;     // response register still held
  } dp_stat_t;

endpackage

@@ rtl/spq_req_if.sv @@
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: enqueue or dequeue with priority and payload tag.
// ----------------------------------------------------------------------------
interface spq_req_if;

  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [spq_pkg::PRIO_W-1:0]  priority_req;
  logic [spq_pkg::TAG_W-1:0]   payload;

  modport source (output valid, req_type, priority_req, payload, input ready);
  modport sink   (input valid, req_type, priority_req, payload, output ready);

endinterface

@@ rtl/spq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: status, removed entry and fill level.
// ----------------------------------------------------------------------------
interface spq_rsp_if;

  logic                        valid;
  logic                        ready;
  logic [spq_pkg::STAT_W-1:0]  status;
  logic [spq_pkg::TAG_W-1:0]   out_payload;
  logic [spq_pkg::PRIO_W-1:0]  out_priority;
  logic [spq_pkg::FILL_W-1:0]  fill_level;

  modport source (output valid, status, out_payload, out_priority, fill_level,
                  input ready);
  modport sink   (input valid, status, out_payload, out_priority, fill_level,
                  output ready);

endinterface

@@ rtl/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// spq_datapath
// Circular entry memory with head/tail pointers, insertion walk pointer,
// request capture and the response register.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_type,
  input  logic [spq_pkg::PRIO_W-1:0]  priority_req,
  input  logic [spq_pkg::TAG_W-1:0]   payload,
  input  spq_pkg::dp_cmd_t            cmd,
  output spq_pkg::dp_stat_t           stat,
  spq_rsp_if.source                   rsp
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = spq_pkg::ENTRY_W;
  localparam int TW = spq_pkg::TAG_W;
  localparam int RW = spq_pkg::PRIO_W;
  localparam int FW = spq_pkg::FILL_W;
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

  logic [EW-1:0] mem [QUEUE_DEPTH];

  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] count;
  logic [PW-1:0] wptr;
  logic [CW-1:0] steps;
  logic          kind;
  logic [RW-1:0] new_prio;
  logic [TW-1:0] new_tag;
  logic [EW-1:0] rdata;
  logic [EW-1:0] popped;
  logic          rsp_valid;

  logic [PW-1:0] prev_ptr;
  logic [PW-1:0] raddr;
  logic          rd_en;
  logic          wr_en;
  logic [EW-1:0] wdata;

  // pointer wrap
  assign prev_ptr = (wptr == '0) ? LAST : wptr - 1'b1;

  // memory port selection
  assign rd_en = cmd.rd_head | cmd.rd_prev;
  assign raddr = cmd.rd_head ? head : prev_ptr;
  assign wr_en = cmd.shift | cmd.place;
  assign wdata = cmd.shift ? rdata : {new_prio, new_tag};

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // request capture and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind     <= req_type;
      new_prio <= priority_req;
      new_tag  <= payload;
    end
    if (cmd.start_enq) begin
      wptr  <= tail;
      steps <= count;
    end else if (cmd.shift) begin
      wptr  <= prev_ptr;
      steps <= steps - 1'b1;
    end
    if (cmd.pop) begin
      popped <= rdata;
    end
  end

  // queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.place) begin
        tail  <= (tail == LAST) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        head  <= (head == LAST) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp.fill_level   <= FW'(count);
      rsp.out_payload  <= '0;
      rsp.out_priority <= '0;
      case (cmd.res_sel)
        spq_pkg::RES_ENQ_OK: rsp.status <= spq_pkg::ST_OK;
        spq_pkg::RES_FULL:   rsp.status <= spq_pkg::ST_FULL;
        spq_pkg::RES_EMPTY:  rsp.status <= spq_pkg::ST_EMPTY;
        spq_pkg::RES_DEQ_OK: begin
          rsp.status       <= spq_pkg::ST_OK;
          rsp.out_payload  <= popped[TW-1:0];
          rsp.out_priority <= popped[EW-1:TW];
        end
        default:             rsp.status <= spq_pkg::ST_OK;
      endcase
    end
  end

  assign rsp.valid = rsp_valid;

  // status to controller
  assign stat.deq_req     = (kind == spq_pkg::REQ_DEQ);
  assign stat.full        = (count == CW'(QUEUE_DEPTH));
  assign stat.empty       = (count == '0);
  assign stat.walk_done   = (steps == '0);
  assign stat.goes_behind = (rdata[EW-1:TW] >= new_prio);
  assign stat.out_busy    = rsp_valid & ~rsp.ready;

endmodule

@@ rtl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: dispatches enqueue/dequeue, steps the insertion walk
// and hands the finished response to the output register.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  spq_pkg::dp_stat_t  stat,
  output spq_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    IDLE,
    DISPATCH,
    ENQ_STEP,
    ENQ_CMP,
    DEQ_DATA,
    FINISH
  } state_t;

  state_t            state;
  state_t            state_next;
  spq_pkg::res_sel_t res_sel;
  spq_pkg::res_sel_t res_sel_next;

  assign in_ready = (state == IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    res_sel_next = res_sel;
    cmd          = '0;
    cmd.res_sel  = res_sel;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = DISPATCH;
        end
      end
      DISPATCH: begin
        if (stat.deq_req) begin
          if (stat.empty) begin
            res_sel_next = spq_pkg::RES_EMPTY;
            state_next   = FINISH;
          end else begin
            cmd.rd_head = 1'b1;
            state_next  = DEQ_DATA;
          end
        end else begin
          if (stat.full) begin
            res_sel_next = spq_pkg::RES_FULL;
            state_next   = FINISH;
          end else begin
            cmd.start_enq = 1'b1;
            state_next    = ENQ_STEP;
          end
        end
      end
      ENQ_STEP: begin
        if (stat.walk_done) begin
          cmd.place    = 1'b1;
          res_sel_next = spq_pkg::RES_ENQ_OK;
          state_next   = FINISH;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = ENQ_CMP;
        end
      end
      ENQ_CMP: begin
        if (stat.goes_behind) begin
          cmd.place    = 1'b1;
          res_sel_next = spq_pkg::RES_ENQ_OK;
          state_next   = FINISH;
        end else begin
          cmd.shift  = 1'b1;
          state_next = ENQ_STEP;
        end
      end
      DEQ_DATA: begin
        cmd.pop      = 1'b1;
        res_sel_next = spq_pkg::RES_DEQ_OK;
        state_next   = FINISH;
      end
      FINISH: begin
        if (!stat.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      res_sel <= spq_pkg::RES_ENQ_OK;
    end else begin
      state   <= state_next;
      res_sel <= res_sel_next;
    end
  end

endmodule

@@ rtl/stable_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded priority queue kept in descending priority order, first in, first
// out among equal priorities.
// ----------------------------------------------------------------------------
// One request is handled at a time. A refused enqueue (full) or a dequeue on
// an empty queue goes from DISPATCH straight to FINISH, where its response is
// loaded; a dequeue passes through DEQ_DATA to remove the head entry. An
// enqueue walks the entry memory from the tail toward the head: ENQ_STEP
// reads the entry in front of the write slot, then ENQ_CMP compares it and
// either writes the new entry into the write slot or moves the read entry, of
// lower priority, back one slot; the walk also ends when the write slot
// reaches the head. The next request is taken in the cycle after the response
// is loaded; a held response stalls the block only when another response is
// ready to replace it. The entry memory needs no clearing after reset.
module stable_priority_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  spq_req_if.sink    req,
  spq_rsp_if.source  rsp
);

  spq_pkg::dp_cmd_t  cmd;
  spq_pkg::dp_stat_t stat;
  logic              in_ready;

  assign req.ready = in_ready;

  // request sequencer
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entry storage and response register
  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req_type     (req.req_type),
    .priority_req (req.priority_req),
    .payload      (req.payload),
    .cmd          (cmd),
    .stat         (stat),
    .rsp          (rsp)
  );

endmodule
